### src/btint_pkg.sv
// ----------------------------------------------------------------------------
// btint_pkg
// Shared types and codes for the breakpoint table interpolator: item
// operation codes, the command record that travels from front to back,
// register indexes and the state types of the sequencers.
// ----------------------------------------------------------------------------
package btint_pkg;

	// Operation codes carried by the op field of an input item.
	localparam logic [2:0] OP_WR_X    = 3'd0;
	localparam logic [2:0] OP_WR_Y    = 3'd1;
	localparam logic [2:0] OP_WR_GRID = 3'd2;
	localparam logic [2:0] OP_LUT_1D  = 3'd3;
	localparam logic [2:0] OP_LUT_2D  = 3'd4;

	// Register indexes on the configuration port (byte address bit 2).
	localparam logic REG_X_COUNT = 1'b0;
	localparam logic REG_Y_COUNT = 1'b1;

	// Command queue geometry.
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PW    = 1;

	typedef enum logic [2:0] {
		CMD_WR_X,
		CMD_WR_Y,
		CMD_WR_GRID,
		CMD_LUT_1D,
		CMD_LUT_2D
	} cmd_kind_t;

	// For writes data is the value to store; for lookups it is the x query.
	typedef struct packed {
		cmd_kind_t          kind;
		logic [3:0]         row;
		logic [3:0]         col;
		logic signed [31:0] data;
		logic signed [31:0] qy;
	} cmd_t;

	// Where a query lies along the x axis.
	typedef enum logic [1:0] {
		CLS_LOW,
		CLS_HIGH,
		CLS_MID
	} cls_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_END_RD,
		ST_CLASSIFY,
		ST_SRCH,
		ST_SCMP,
		ST_BP_RD,
		ST_BP_LATCH,
		ST_GRID_RD,
		ST_GRID_DAT,
		ST_LERP_WAIT,
		ST_FIN
	} back_state_t;

	typedef enum logic [1:0] {
		LS_IDLE,
		LS_MUL,
		LS_DIV,
		LS_DONE
	} lerp_state_t;

	// Request to the interpolation unit.
	typedef struct packed {
		logic               start;
		logic signed [31:0] q;
		logic signed [31:0] q0;
		logic signed [31:0] q1;
		logic signed [31:0] v0;
		logic signed [31:0] v1;
	} lerp_req_t;

endpackage

### src/btint_ram.sv
// ----------------------------------------------------------------------------
// btint_ram
// Generic memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module btint_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [WIDTH-1:0]           wdata,
	input  logic [$clog2(DEPTH)-1:0]   raddr0,
	input  logic [$clog2(DEPTH)-1:0]   raddr1,
	output logic [WIDTH-1:0]           rdata0,
	output logic [WIDTH-1:0]           rdata1
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule

### src/btint_front.sv
// ----------------------------------------------------------------------------
// btint_front
// Decodes incoming items into commands and drops those with no effect.
// ----------------------------------------------------------------------------
module btint_front #(
	parameter int MAX_X_POINTS = 16,
	parameter int MAX_Y_POINTS = 16
) (
	input  logic                push,
	input  logic [2:0]          op,
	input  logic [3:0]          row,
	input  logic [3:0]          col,
	input  logic signed [31:0]  write_value,
	input  logic signed [31:0]  query_x,
	input  logic signed [31:0]  query_y,
	input  logic                q_full,
	output logic                enq,
	output btint_pkg::cmd_t     cmd
);

	logic keep;
	logic col_ok;
	logic row_ok;

	assign col_ok = 32'(col) < MAX_X_POINTS;
	assign row_ok = 32'(row) < MAX_Y_POINTS;

	// Writes out of range and unused codes change nothing and are dropped here.
	always_comb begin
		cmd.row  = row;
		cmd.col  = col;
		cmd.qy   = query_y;
		cmd.data = query_x;
		cmd.kind = btint_pkg::CMD_LUT_1D;
		keep     = 1'b0;
		case (op)
			btint_pkg::OP_WR_X: begin
				cmd.kind = btint_pkg::CMD_WR_X;
				cmd.data = write_value;
				keep     = col_ok;
			end
			btint_pkg::OP_WR_Y: begin
				cmd.kind = btint_pkg::CMD_WR_Y;
				cmd.data = write_value;
				keep     = row_ok;
			end
			btint_pkg::OP_WR_GRID: begin
				cmd.kind = btint_pkg::CMD_WR_GRID;
				cmd.data = write_value;
				keep     = col_ok && row_ok;
			end
			btint_pkg::OP_LUT_1D: begin
				cmd.kind = btint_pkg::CMD_LUT_1D;
				keep     = 1'b1;
			end
			btint_pkg::OP_LUT_2D: begin
				cmd.kind = btint_pkg::CMD_LUT_2D;
				keep     = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign enq = push && !q_full && keep;

endmodule

### src/btint_cmdq.sv
// ----------------------------------------------------------------------------
// btint_cmdq
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module btint_cmdq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            enq,
	input  btint_pkg::cmd_t din,
	input  logic            deq,
	output btint_pkg::cmd_t dout,
	output logic            full,
	output logic            empty
);

	localparam int CW = $clog2(btint_pkg::CMDQ_DEPTH + 1);

	btint_pkg::cmd_t                 slot_q [btint_pkg::CMDQ_DEPTH];
	logic [btint_pkg::CMDQ_PW-1:0]   wptr_q;
	logic [btint_pkg::CMDQ_PW-1:0]   rptr_q;
	logic [CW-1:0]                   cnt_q;
	logic                            do_enq;
	logic                            do_deq;

	assign full   = cnt_q == CW'(btint_pkg::CMDQ_DEPTH);
	assign empty  = cnt_q == '0;
	assign do_enq = enq && !full;
	assign do_deq = deq && !empty;
	assign dout   = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_enq) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_deq) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (do_enq && !do_deq) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_deq && !do_enq) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_enq) begin
			slot_q[wptr_q] <= din;
		end
	end

endmodule

### src/btint_lerp.sv
// ----------------------------------------------------------------------------
// btint_lerp
// Linear interpolation v0 + trunc((q-q0)*(v1-v0)/(q1-q0)), wrapped to 32
// bits. One registered multiply, then a restoring divider retiring two
// quotient bits per cycle.
// ----------------------------------------------------------------------------
module btint_lerp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  btint_pkg::lerp_req_t  req,
	output logic                  done,
	output logic signed [31:0]    result
);

	localparam int STEPS = 33;
	localparam int CNTW  = $clog2(STEPS);

	btint_pkg::lerp_state_t state_q;
	btint_pkg::lerp_state_t state_d;

	logic [32:0]        ma_q;
	logic [32:0]        mb_q;
	logic [32:0]        md_q;
	logic               neg_q;
	logic               dz_q;
	logic signed [31:0] v0_q;
	logic [65:0]        dvd_q;
	logic [32:0]        rem_q;
	logic [31:0]        quo_q;
	logic [CNTW-1:0]    cnt_q;

	logic signed [32:0] a;
	logic signed [32:0] b;
	logic signed [32:0] d;
	logic [33:0]        r1;
	logic [33:0]        r2;
	logic [32:0]        rem1;
	logic [32:0]        rem2;
	logic               qb1;
	logic               qb2;
	logic [31:0]        sum;

	assign a = $signed({req.q[31], req.q}) - $signed({req.q0[31], req.q0});
	assign b = $signed({req.v1[31], req.v1}) - $signed({req.v0[31], req.v0});
	assign d = $signed({req.q1[31], req.q1}) - $signed({req.q0[31], req.q0});

	// Two restoring division steps per cycle.
	always_comb begin
		r1 = {rem_q, dvd_q[65]};
		qb1 = r1 >= 34'(md_q);
		rem1 = qb1 ? 33'(r1 - 34'(md_q)) : r1[32:0];
		r2 = {rem1, dvd_q[64]};
		qb2 = r2 >= 34'(md_q);
		rem2 = qb2 ? 33'(r2 - 34'(md_q)) : r2[32:0];
	end

	assign sum = neg_q ? (32'(v0_q) - quo_q) : (32'(v0_q) + quo_q);

	// A new request may also arrive in the cycle that presents a result.
	always_comb begin
		state_d = state_q;
		case (state_q)
			btint_pkg::LS_IDLE: begin
				if (req.start) begin
					state_d = (d == '0) ? btint_pkg::LS_DONE : btint_pkg::LS_MUL;
				end
			end
			btint_pkg::LS_MUL: begin
				state_d = btint_pkg::LS_DIV;
			end
			btint_pkg::LS_DIV: begin
				if (cnt_q == CNTW'(STEPS - 1)) begin
					state_d = btint_pkg::LS_DONE;
				end
			end
			btint_pkg::LS_DONE: begin
				if (req.start) begin
					state_d = (d == '0) ? btint_pkg::LS_DONE : btint_pkg::LS_MUL;
				end else begin
					state_d = btint_pkg::LS_IDLE;
				end
			end
			default: begin
				state_d = btint_pkg::LS_IDLE;
			end
		endcase
	end

	always_comb begin
		done   = state_q == btint_pkg::LS_DONE;
		result = dz_q ? v0_q : $signed(sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= btint_pkg::LS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			btint_pkg::LS_IDLE, btint_pkg::LS_DONE: begin
				if (req.start) begin
					ma_q  <= a[32] ? 33'(~a + 33'd1) : 33'(a);
					mb_q  <= b[32] ? 33'(~b + 33'd1) : 33'(b);
					md_q  <= d[32] ? 33'(~d + 33'd1) : 33'(d);
					neg_q <= a[32] ^ b[32] ^ d[32];
					dz_q  <= d == '0;
					v0_q  <= req.v0;
				end
			end
			btint_pkg::LS_MUL: begin
				dvd_q <= ma_q * mb_q;
				rem_q <= '0;
				quo_q <= '0;
				cnt_q <= '0;
			end
			btint_pkg::LS_DIV: begin
				dvd_q <= {dvd_q[63:0], 2'b00};
				rem_q <= rem2;
				quo_q <= {quo_q[29:0], qb1, qb2};
				cnt_q <= cnt_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

### src/btint_back.sv
// ----------------------------------------------------------------------------
// btint_back
// Executes commands: table writes, breakpoint searches, grid reads and the
// interpolation sequence, and holds the finished result for the consumer.
// ----------------------------------------------------------------------------
module btint_back #(
	parameter int MAX_X_POINTS = 16,
	parameter int MAX_Y_POINTS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [4:0]         x_count,
	input  logic [4:0]         y_count,
	input  logic               q_empty,
	input  btint_pkg::cmd_t    q_head,
	output logic               q_pop,
	input  logic               pop,
	output logic               empty,
	output logic signed [31:0] result_value,
	output logic               status
);

	localparam int XAW   = $clog2(MAX_X_POINTS);
	localparam int YAW   = $clog2(MAX_Y_POINTS);
	localparam int GD    = MAX_X_POINTS * MAX_Y_POINTS;
	localparam int GAW   = $clog2(GD);
	localparam int XNMAX = (MAX_X_POINTS < 31) ? MAX_X_POINTS : 31;
	localparam int YNMAX = (MAX_Y_POINTS < 31) ? MAX_Y_POINTS : 31;
	localparam int XCW   = $clog2(XNMAX + 1);
	localparam int YCW   = $clog2(YNMAX + 1);
	localparam int NW    = (XCW > YCW) ? XCW : YCW;
	localparam int SIW   = NW + 2;

	btint_pkg::back_state_t state_q;
	btint_pkg::back_state_t state_d;

	btint_pkg::cmd_t        cmd_q;
	logic                   ax_q;
	btint_pkg::cls_t        xcls_q;
	logic [XAW-1:0]         ix_q;
	logic [YAW-1:0]         iy_q;
	logic signed [SIW-1:0]  lo_q;
	logic signed [SIW-1:0]  hi_q;
	logic signed [SIW-1:0]  mid_q;
	logic signed [SIW-1:0]  idx_q;
	logic signed [31:0]     xa_q;
	logic signed [31:0]     xb_q;
	logic signed [31:0]     ya_q;
	logic signed [31:0]     yb_q;
	logic signed [31:0]     z0_q;
	logic                   row_sel_q;
	logic                   ylerp_q;
	logic signed [31:0]     res_q;
	logic                   res_st_q;
	logic                   out_valid_q;
	logic signed [31:0]     out_value_q;
	logic                   out_st_q;

	logic [XCW-1:0]         nx;
	logic [YCW-1:0]         ny;
	logic signed [SIW-1:0]  s_n;
	logic signed [31:0]     s_v;
	logic signed [SIW-1:0]  mid;
	logic signed [SIW-1:0]  mid1;
	logic signed [SIW-1:0]  ia0;
	logic signed [SIW-1:0]  ia1;
	logic [XAW-1:0]         c0;
	logic [XAW-1:0]         c1;
	logic [YAW-1:0]         grow;
	logic [GAW-1:0]         gbase;
	logic [GAW-1:0]         ga0;
	logic [GAW-1:0]         ga1;

	logic                   xwe;
	logic                   ywe;
	logic                   gwe;
	logic [XAW-1:0]         xwa;
	logic [YAW-1:0]         ywa;
	logic [GAW-1:0]         gwa;
	logic [31:0]            xd0;
	logic [31:0]            xd1;
	logic [31:0]            yd0;
	logic [31:0]            yd1;
	logic [31:0]            gd0;
	logic [31:0]            gd1;
	logic signed [31:0]     bd0;
	logic signed [31:0]     bd1;

	btint_pkg::lerp_req_t   lreq;
	logic                   ldone;
	logic signed [31:0]     lres;

	logic                   row_done;
	logic signed [31:0]     zval;
	logic                   y_low;
	logic                   y_high;
	logic                   is_2d;

	assign nx = (32'(x_count) > MAX_X_POINTS) ? XCW'(MAX_X_POINTS) : XCW'(x_count);
	assign ny = (32'(y_count) > MAX_Y_POINTS) ? YCW'(MAX_Y_POINTS) : YCW'(y_count);

	assign is_2d = cmd_q.kind == btint_pkg::CMD_LUT_2D;
	assign s_n   = ax_q ? SIW'(ny) : SIW'(nx);
	assign s_v   = ax_q ? cmd_q.qy : cmd_q.data;
	assign bd0   = ax_q ? $signed(yd0) : $signed(xd0);
	assign bd1   = ax_q ? $signed(yd1) : $signed(xd1);
	assign mid   = (lo_q + hi_q) >>> 1;
	assign mid1  = mid + SIW'(1);

	assign row_done = (state_q == btint_pkg::ST_GRID_DAT && xcls_q != btint_pkg::CLS_MID)
		|| (state_q == btint_pkg::ST_LERP_WAIT && ldone && !ylerp_q);
	assign zval   = (state_q == btint_pkg::ST_GRID_DAT) ? $signed(gd0) : lres;
	assign y_low  = cmd_q.qy <= ya_q;
	assign y_high = cmd_q.qy >= yb_q;

	// Grid row and columns for the current row read.
	always_comb begin
		if (!is_2d) begin
			grow = '0;
		end else if (row_sel_q) begin
			grow = iy_q + YAW'(1);
		end else begin
			grow = iy_q;
		end
		case (xcls_q)
			btint_pkg::CLS_LOW: begin
				c0 = '0;
				c1 = '0;
			end
			btint_pkg::CLS_HIGH: begin
				c0 = XAW'(nx) - XAW'(1);
				c1 = XAW'(nx) - XAW'(1);
			end
			default: begin
				c0 = ix_q;
				c1 = ix_q + XAW'(1);
			end
		endcase
		gbase = GAW'(grow) * GAW'(MAX_X_POINTS);
		ga0   = gbase + GAW'(c0);
		ga1   = gbase + GAW'(c1);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			btint_pkg::ST_IDLE: begin
				if (!q_empty) begin
					case (q_head.kind)
						btint_pkg::CMD_LUT_1D: begin
							if (nx == '0) begin
								state_d = btint_pkg::ST_FIN;
							end else if (nx == XCW'(1)) begin
								state_d = btint_pkg::ST_GRID_RD;
							end else begin
								state_d = btint_pkg::ST_END_RD;
							end
						end
						btint_pkg::CMD_LUT_2D: begin
							if (nx < XCW'(2) || ny < YCW'(2)) begin
								state_d = btint_pkg::ST_FIN;
							end else begin
								state_d = btint_pkg::ST_END_RD;
							end
						end
						default: begin
							state_d = btint_pkg::ST_IDLE;
						end
					endcase
				end
			end
			btint_pkg::ST_END_RD: begin
				state_d = btint_pkg::ST_CLASSIFY;
			end
			btint_pkg::ST_CLASSIFY: begin
				if (s_v <= bd0 || s_v >= bd1) begin
					if (ax_q) begin
						state_d = btint_pkg::ST_BP_RD;
					end else if (is_2d) begin
						state_d = btint_pkg::ST_END_RD;
					end else begin
						state_d = btint_pkg::ST_GRID_RD;
					end
				end else begin
					state_d = btint_pkg::ST_SRCH;
				end
			end
			btint_pkg::ST_SRCH: begin
				if (lo_q > hi_q || mid1 >= s_n) begin
					state_d = btint_pkg::ST_BP_RD;
				end else begin
					state_d = btint_pkg::ST_SCMP;
				end
			end
			btint_pkg::ST_SCMP: begin
				if (s_v < bd0 || s_v > bd1) begin
					state_d = btint_pkg::ST_SRCH;
				end else begin
					state_d = btint_pkg::ST_BP_RD;
				end
			end
			btint_pkg::ST_BP_RD: begin
				state_d = btint_pkg::ST_BP_LATCH;
			end
			btint_pkg::ST_BP_LATCH: begin
				if (!ax_q && is_2d) begin
					state_d = btint_pkg::ST_END_RD;
				end else begin
					state_d = btint_pkg::ST_GRID_RD;
				end
			end
			btint_pkg::ST_GRID_RD: begin
				state_d = btint_pkg::ST_GRID_DAT;
			end
			btint_pkg::ST_GRID_DAT, btint_pkg::ST_LERP_WAIT: begin
				if (row_done) begin
					if (!is_2d) begin
						state_d = btint_pkg::ST_FIN;
					end else if (!row_sel_q) begin
						state_d = btint_pkg::ST_GRID_RD;
					end else if (y_low || y_high) begin
						state_d = btint_pkg::ST_FIN;
					end else begin
						state_d = btint_pkg::ST_LERP_WAIT;
					end
				end else if (state_q == btint_pkg::ST_GRID_DAT) begin
					state_d = btint_pkg::ST_LERP_WAIT;
				end else if (ldone) begin
					state_d = btint_pkg::ST_FIN;
				end
			end
			btint_pkg::ST_FIN: begin
				if (!out_valid_q) begin
					state_d = btint_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = btint_pkg::ST_IDLE;
			end
		endcase
	end

	// Memory ports, queue pop and interpolation requests.
	always_comb begin
		q_pop = 1'b0;
		xwe   = 1'b0;
		ywe   = 1'b0;
		gwe   = 1'b0;
		xwa   = XAW'(q_head.col);
		ywa   = YAW'(q_head.row);
		gwa   = GAW'(q_head.row) * GAW'(MAX_X_POINTS) + GAW'(q_head.col);
		ia0   = '0;
		ia1   = s_n - SIW'(1);
		lreq  = '0;
		case (state_q)
			btint_pkg::ST_IDLE: begin
				q_pop = !q_empty;
				xwe   = !q_empty && q_head.kind == btint_pkg::CMD_WR_X;
				ywe   = !q_empty && q_head.kind == btint_pkg::CMD_WR_Y;
				gwe   = !q_empty && q_head.kind == btint_pkg::CMD_WR_GRID;
			end
			btint_pkg::ST_SRCH: begin
				ia0 = mid;
				ia1 = mid1;
			end
			btint_pkg::ST_BP_RD: begin
				ia0 = idx_q;
				ia1 = idx_q + SIW'(1);
			end
			btint_pkg::ST_GRID_DAT: begin
				if (xcls_q == btint_pkg::CLS_MID) begin
					lreq.start = 1'b1;
					lreq.q     = cmd_q.data;
					lreq.q0    = xa_q;
					lreq.q1    = xb_q;
					lreq.v0    = $signed(gd0);
					lreq.v1    = $signed(gd1);
				end
			end
			default: begin
			end
		endcase
		if (row_done && is_2d && row_sel_q && !y_low && !y_high) begin
			lreq.start = 1'b1;
			lreq.q     = cmd_q.qy;
			lreq.q0    = ya_q;
			lreq.q1    = yb_q;
			lreq.v0    = z0_q;
			lreq.v1    = zval;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= btint_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == btint_pkg::ST_FIN && !out_valid_q) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			btint_pkg::ST_IDLE: begin
				cmd_q     <= q_head;
				ax_q      <= 1'b0;
				row_sel_q <= 1'b0;
				ylerp_q   <= 1'b0;
				xcls_q    <= btint_pkg::CLS_LOW;
				res_q     <= '0;
				res_st_q  <= q_head.kind == btint_pkg::CMD_LUT_2D;
			end
			btint_pkg::ST_CLASSIFY: begin
				lo_q <= '0;
				hi_q <= s_n - SIW'(1);
				if (ax_q) begin
					if (s_v <= bd0) begin
						idx_q <= '0;
					end else if (s_v >= bd1) begin
						idx_q <= s_n - SIW'(2);
					end
				end else begin
					if (s_v <= bd0) begin
						xcls_q <= btint_pkg::CLS_LOW;
						ax_q   <= 1'b1;
					end else if (s_v >= bd1) begin
						xcls_q <= btint_pkg::CLS_HIGH;
						ax_q   <= 1'b1;
					end else begin
						xcls_q <= btint_pkg::CLS_MID;
					end
				end
			end
			btint_pkg::ST_SRCH: begin
				mid_q <= mid;
				if (lo_q > hi_q || mid1 >= s_n) begin
					idx_q <= '0;
				end
			end
			btint_pkg::ST_SCMP: begin
				if (s_v < bd0) begin
					hi_q <= mid_q - SIW'(1);
				end else if (s_v > bd1) begin
					lo_q <= mid_q + SIW'(1);
				end else begin
					idx_q <= mid_q;
				end
			end
			btint_pkg::ST_BP_LATCH: begin
				if (ax_q) begin
					iy_q <= YAW'(idx_q);
					ya_q <= $signed(yd0);
					yb_q <= $signed(yd1);
				end else begin
					ix_q <= XAW'(idx_q);
					xa_q <= $signed(xd0);
					xb_q <= $signed(xd1);
					ax_q <= 1'b1;
				end
			end
			btint_pkg::ST_GRID_DAT, btint_pkg::ST_LERP_WAIT: begin
				if (row_done) begin
					if (!is_2d) begin
						res_q <= zval;
					end else if (!row_sel_q) begin
						z0_q      <= zval;
						row_sel_q <= 1'b1;
					end else if (y_low) begin
						res_q <= z0_q;
					end else if (y_high) begin
						res_q <= zval;
					end else begin
						ylerp_q <= 1'b1;
					end
				end else if (state_q == btint_pkg::ST_LERP_WAIT && ldone) begin
					res_q <= lres;
				end
			end
			btint_pkg::ST_FIN: begin
				if (!out_valid_q) begin
					out_value_q <= res_q;
					out_st_q    <= res_st_q && (nx < XCW'(2) || ny < YCW'(2));
				end
			end
			default: begin
			end
		endcase
	end

	assign empty        = !out_valid_q;
	assign result_value = out_value_q;
	assign status       = out_st_q;

	btint_ram #(.WIDTH(32), .DEPTH(MAX_X_POINTS)) u_xbp (
		.clk    (clk),
		.we     (xwe),
		.waddr  (xwa),
		.wdata  (q_head.data),
		.raddr0 (XAW'(ia0)),
		.raddr1 (XAW'(ia1)),
		.rdata0 (xd0),
		.rdata1 (xd1)
	);

	btint_ram #(.WIDTH(32), .DEPTH(MAX_Y_POINTS)) u_ybp (
		.clk    (clk),
		.we     (ywe),
		.waddr  (ywa),
		.wdata  (q_head.data),
		.raddr0 (YAW'(ia0)),
		.raddr1 (YAW'(ia1)),
		.rdata0 (yd0),
		.rdata1 (yd1)
	);

	btint_ram #(.WIDTH(32), .DEPTH(GD)) u_grid (
		.clk    (clk),
		.we     (gwe),
		.waddr  (gwa),
		.wdata  (q_head.data),
		.raddr0 (ga0),
		.raddr1 (ga1),
		.rdata0 (gd0),
		.rdata1 (gd1)
	);

	btint_lerp u_lerp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (lreq),
		.done   (ldone),
		.result (lres)
	);

endmodule

### src/breakpoint_table_interpolator.sv
// ----------------------------------------------------------------------------
// breakpoint_table_interpolator
// One- and two-axis breakpoint table lookup with linear and bilinear
// interpolation, fed and drained through queue-style channels.
// ----------------------------------------------------------------------------
// Items enter on the push/full channel: table writes (x breakpoint, y
// breakpoint, grid entry) and lookups. Each lookup produces one transaction on
// the empty/pop channel carrying result_value and status; writes and unused
// op codes produce none. x_count and y_count are set over the APB port, whose
// register 0 is at byte address 0 and register 1 at byte address 4.
// A write item is stored while the execution unit stays idle. A 1D lookup with
// no breakpoints goes straight to its end; otherwise the binary searches probe
// in a search and a compare state, and each interpolation passes through the
// shared multiply and two-bit-per-cycle divider.
// Items are worked on one at a time; a two-entry command queue lets the
// producer push ahead while a lookup is running.
// Reset clears the counts, the queue and the result valid flag; table contents
// are undefined until written. When the consumer stalls, the finished result
// is held and the next lookup waits at its end until the result is taken.
// ----------------------------------------------------------------------------
module breakpoint_table_interpolator #(
	parameter int MAX_X_POINTS = 16,
	parameter int MAX_Y_POINTS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [2:0]         op,
	input  logic [3:0]         row,
	input  logic [3:0]         col,
	input  logic signed [31:0] write_value,
	input  logic signed [31:0] query_x,
	input  logic signed [31:0] query_y,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] result_value,
	output logic               status,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [4:0]      x_count_q;
	logic [4:0]      y_count_q;
	logic            cfg_wr;
	logic            q_enq;
	logic            q_full;
	logic            q_empty;
	logic            q_pop;
	btint_pkg::cmd_t q_din;
	btint_pkg::cmd_t q_head;

	// The APB port is always ready; the register is picked by address bit 2.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == btint_pkg::REG_Y_COUNT) ? 32'(y_count_q) : 32'(x_count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_count_q <= '0;
			y_count_q <= '0;
		end else if (cfg_wr) begin
			if (paddr[2] == btint_pkg::REG_X_COUNT) begin
				x_count_q <= pwdata[4:0];
			end else begin
				y_count_q <= pwdata[4:0];
			end
		end
	end

	// The front only classifies; full is driven by the command queue.
	assign full = q_full;

	btint_front #(
		.MAX_X_POINTS (MAX_X_POINTS),
		.MAX_Y_POINTS (MAX_Y_POINTS)
	) u_front (
		.push        (push),
		.op          (op),
		.row         (row),
		.col         (col),
		.write_value (write_value),
		.query_x     (query_x),
		.query_y     (query_y),
		.q_full      (q_full),
		.enq         (q_enq),
		.cmd         (q_din)
	);

	btint_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.enq    (q_enq),
		.din    (q_din),
		.deq    (q_pop),
		.dout   (q_head),
		.full   (q_full),
		.empty  (q_empty)
	);

	btint_back #(
		.MAX_X_POINTS (MAX_X_POINTS),
		.MAX_Y_POINTS (MAX_Y_POINTS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.x_count      (x_count_q),
		.y_count      (y_count_q),
		.q_empty      (q_empty),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.pop          (pop),
		.empty        (empty),
		.result_value (result_value),
		.status       (status)
	);

	// A flagged lookup always carries a zero value.
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status) |-> (result_value == 32'sd0))
		else $error("flagged result with nonzero value");

	// A configuration write to x_count lands in the register.
	a_xcount_wr: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr && paddr[2] == btint_pkg::REG_X_COUNT) |=> (x_count_q == $past(pwdata[4:0])))
		else $error("x_count write lost");

	// The command queue never reports full and empty together.
	a_q_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_full && q_empty))
		else $error("command queue full and empty at once");

	// Nothing is taken from the queue while it is empty.
	a_q_pop: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("command queue popped while empty");

endmodule
